// ===== hdl/ibba_pkg.sv =====
// Shared types and constants for the inode and block bitmap allocator.
// Used by the controller, the datapath, the top level and the checker.
package ibba_pkg;

  // File store geometry
  localparam int INODE_COUNT      = 32;
  localparam int BLOCK_TOTAL      = 64;
  localparam int BLOCKS_PER_FILE  = 8;
  localparam int BLOCK_BYTES      = 4096;
  localparam int FIRST_DATA_BLOCK = 5;
  localparam int RESERVED_BLOCKS  = 4;

  // Field widths
  localparam int INO_W   = $clog2(INODE_COUNT);
  localparam int BLK_W   = $clog2(BLOCK_TOTAL);
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 4;
  localparam int CMD_W   = 2;
  localparam int BPF_W   = $clog2(BLOCKS_PER_FILE);
  localparam int LIST_AW = INO_W + BPF_W;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // Bitmap masks: blocks marked used by a format, blocks never handed out
  localparam logic [BLOCK_TOTAL-1:0] RESERVED_MASK =
      (BLOCK_TOTAL'(1) << RESERVED_BLOCKS) - BLOCK_TOTAL'(1);
  localparam logic [BLOCK_TOTAL-1:0] LOW_MASK =
      (BLOCK_TOTAL'(1) << FIRST_DATA_BLOCK) - BLOCK_TOTAL'(1);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_INODE = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_LIST,
    EMIT_ERR,
    EMIT_FMT
  } emit_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    format;
    logic    check;
    logic    claim;
    logic    commit;
    logic    rec_load;
    emit_e   emit;
    status_e err;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic inode_free;
    logic too_big;
    logic blk_found;
    logic claim_done;
    logic list_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/ibba_ctrl.sv =====
// Controller state machine for the bitmap allocator.
// Depends on ibba_pkg; drives ibba_datapath through ctrl_cmd_t.
module ibba_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ibba_pkg::CMD_W-1:0] cmd_i,
  input  ibba_pkg::dp_stat_t      stat_i,
  output ibba_pkg::ctrl_cmd_t     ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACHECK,
    S_ACLAIM,
    S_ACOMMIT,
    S_LREC,
    S_LLOAD,
    S_RD,
    S_EMIT,
    S_ERR,
    S_FMT
  } state_e;

  state_e             state_q;
  ibba_pkg::status_e  err_q;
  logic               accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Command decode per state
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.emit     = ibba_pkg::EMIT_NONE;
    ctrl_o.err      = err_q;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.capture = accept;
        ctrl_o.format  = accept && (cmd_i == ibba_pkg::CMD_FORMAT);
      end
      S_ACHECK:  ctrl_o.check    = stat_i.inode_free && !stat_i.too_big;
      S_ACLAIM:  ctrl_o.claim    = !stat_i.claim_done && stat_i.blk_found;
      S_ACOMMIT: ctrl_o.commit   = 1'b1;
      S_LLOAD:   ctrl_o.rec_load = 1'b1;
      S_EMIT: if (stat_i.out_free) ctrl_o.emit = ibba_pkg::EMIT_LIST;
      S_ERR:  if (stat_i.out_free) ctrl_o.emit = ibba_pkg::EMIT_ERR;
      S_FMT:  if (stat_i.out_free) ctrl_o.emit = ibba_pkg::EMIT_FMT;
      default: ;
    endcase
  end

  // State and error code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ibba_pkg::ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            priority if (cmd_i == ibba_pkg::CMD_FORMAT) state_q <= S_FMT;
            else if (cmd_i == ibba_pkg::CMD_ALLOC)      state_q <= S_ACHECK;
            else if (cmd_i == ibba_pkg::CMD_LOOKUP)     state_q <= S_LREC;
            else                                        state_q <= S_IDLE;
          end
        end
        S_ACHECK: begin
          priority if (!stat_i.inode_free) begin
            err_q   <= ibba_pkg::ST_NO_INODE;
            state_q <= S_ERR;
          end else if (stat_i.too_big) begin
            err_q   <= ibba_pkg::ST_TOO_BIG;
            state_q <= S_ERR;
          end else begin
            state_q <= S_ACLAIM;
          end
        end
        S_ACLAIM: begin
          priority if (stat_i.claim_done) begin
            state_q <= S_ACOMMIT;
          end else if (!stat_i.blk_found) begin
            err_q   <= ibba_pkg::ST_NO_SPACE;
            state_q <= S_ERR;
          end
        end
        S_ACOMMIT: state_q <= S_RD;
        S_LREC:    state_q <= S_LLOAD;
        S_LLOAD:   state_q <= S_RD;
        S_RD:      state_q <= S_EMIT;
        S_EMIT: begin
          if (stat_i.out_free) state_q <= stat_i.list_last ? S_IDLE : S_RD;
        end
        S_ERR, S_FMT: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/ibba_datapath.sv =====
// Datapath of the bitmap allocator: bitmaps, inode table memories,
// free-slot pickers and the output register. Depends on ibba_pkg.
module ibba_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ibba_pkg::ctrl_cmd_t              ctrl_i,
  output ibba_pkg::dp_stat_t               stat_o,
  input  logic [ibba_pkg::LEN_W-1:0]       file_length_i,
  input  logic [ibba_pkg::INO_W-1:0]       inode_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [ibba_pkg::INO_W-1:0]       inode_number_o,
  output logic [ibba_pkg::BLK_W-1:0]       block_number_o,
  output logic [ibba_pkg::LEN_W-1:0]       stored_length_o,
  output logic [ibba_pkg::CNT_W-1:0]       stored_blocks_o,
  output logic                             last_o
);

  localparam int INO_W  = ibba_pkg::INO_W;
  localparam int BLK_W  = ibba_pkg::BLK_W;
  localparam int LEN_W  = ibba_pkg::LEN_W;
  localparam int CNT_W  = ibba_pkg::CNT_W;
  localparam int BPF_W  = ibba_pkg::BPF_W;
  localparam int NEED_W = LEN_W + 1;
  localparam int NI     = ibba_pkg::INODE_COUNT;
  localparam int NB     = ibba_pkg::BLOCK_TOTAL;
  localparam int LIST_AW_T = ibba_pkg::LIST_AW;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] len;
  } inode_rec_t;

  // Bitmaps (in_use doubles as the valid bit of each inode table row)
  logic [NI-1:0]    in_use_q;
  logic [NB-1:0]    blk_used_q;

  // Inode table memories
  inode_rec_t       rec_mem [NI];
  logic [BLK_W-1:0] list_mem [NI*ibba_pkg::BLOCKS_PER_FILE];
  inode_rec_t       rec_rd_q;
  logic [BLK_W-1:0] list_rd_q;

  // Working registers of the current command
  logic [LEN_W-1:0] len_q;
  logic [INO_W-1:0] ino_q;
  logic [CNT_W-1:0] need_q;
  logic [CNT_W-1:0] idx_q;
  logic [NB-1:0]    claim_mask_q;

  // Output register
  logic                 out_valid_q;
  ibba_pkg::status_e    out_status_q;
  logic [INO_W-1:0]     out_ino_q;
  logic [BLK_W-1:0]     out_blk_q;
  logic [LEN_W-1:0]     out_len_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_last_q;

  logic [NEED_W-1:0]    need_full;
  logic [NB-1:0]        search_used;
  logic                 ino_found;
  logic [INO_W-1:0]     ino_pick;
  logic                 blk_found;
  logic [BLK_W-1:0]     blk_pick;
  logic [LIST_AW_T-1:0] list_addr;
  logic                 list_last;
  logic                 out_free;

  // Blocks needed: ceiling of length over block size
  assign need_full = (NEED_W'(len_q) + NEED_W'(ibba_pkg::BLOCK_BYTES - 1))
                     >> ibba_pkg::BLOCK_SHIFT;

  // Lowest free inode
  always_comb begin
    ino_found = 1'b0;
    ino_pick  = '0;
    for (int i = NI - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        ino_found = 1'b1;
        ino_pick  = INO_W'(i);
      end
    end
  end

  // Lowest free data block, counting blocks claimed by this command
  assign search_used = blk_used_q | claim_mask_q | ibba_pkg::LOW_MASK;

  always_comb begin
    blk_found = 1'b0;
    blk_pick  = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (!search_used[i]) begin
        blk_found = 1'b1;
        blk_pick  = BLK_W'(i);
      end
    end
  end

  assign list_addr = {ino_q, idx_q[BPF_W-1:0]};
  assign list_last = (need_q == '0) || (CNT_W'(idx_q + CNT_W'(1)) == need_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o            = '0;
    stat_o.inode_free = ino_found;
    stat_o.too_big    = need_full > NEED_W'(ibba_pkg::BLOCKS_PER_FILE);
    stat_o.blk_found  = blk_found;
    stat_o.claim_done = (idx_q == need_q);
    stat_o.list_last  = list_last;
    stat_o.out_free   = out_free;
  end

  // Bitmaps and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      blk_used_q  <= ibba_pkg::RESERVED_MASK;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.format) begin
        in_use_q   <= '0;
        blk_used_q <= ibba_pkg::RESERVED_MASK;
      end
      if (ctrl_i.commit) begin
        in_use_q[ino_q] <= 1'b1;
        blk_used_q      <= blk_used_q | claim_mask_q;
      end
      if (ctrl_i.emit != ibba_pkg::EMIT_NONE) out_valid_q <= 1'b1;
      else if (out_ready_i)                   out_valid_q <= 1'b0;
    end
  end

  // Inode table memories, registered reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) rec_mem[ino_q] <= '{cnt: need_q, len: len_q};
    if (ctrl_i.claim)  list_mem[list_addr] <= blk_pick;
    rec_rd_q  <= rec_mem[ino_q];
    list_rd_q <= list_mem[list_addr];
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      len_q <= file_length_i;
      ino_q <= inode_index_i;
    end
    if (ctrl_i.check) begin
      ino_q        <= ino_pick;
      need_q       <= CNT_W'(need_full);
      idx_q        <= '0;
      claim_mask_q <= '0;
    end
    if (ctrl_i.claim) begin
      claim_mask_q[blk_pick] <= 1'b1;
      idx_q                  <= idx_q + CNT_W'(1);
    end
    if (ctrl_i.commit) idx_q <= '0;
    if (ctrl_i.rec_load) begin
      // a free inode reads as an empty row
      len_q  <= in_use_q[ino_q] ? rec_rd_q.len : '0;
      need_q <= in_use_q[ino_q] ? rec_rd_q.cnt : '0;
      idx_q  <= '0;
    end
    if (ctrl_i.emit == ibba_pkg::EMIT_LIST) idx_q <= idx_q + CNT_W'(1);
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.emit)
      ibba_pkg::EMIT_LIST: begin
        out_status_q <= ibba_pkg::ST_OK;
        out_ino_q    <= ino_q;
        out_blk_q    <= (need_q == '0) ? '0 : list_rd_q;
        out_len_q    <= len_q;
        out_cnt_q    <= need_q;
        out_last_q   <= list_last;
      end
      ibba_pkg::EMIT_ERR, ibba_pkg::EMIT_FMT: begin
        out_status_q <= (ctrl_i.emit == ibba_pkg::EMIT_ERR) ? ctrl_i.err
                                                            : ibba_pkg::ST_OK;
        out_ino_q    <= '0;
        out_blk_q    <= '0;
        out_len_q    <= '0;
        out_cnt_q    <= '0;
        out_last_q   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign inode_number_o  = out_ino_q;
  assign block_number_o  = out_blk_q;
  assign stored_length_o = out_len_q;
  assign stored_blocks_o = out_cnt_q;
  assign last_o          = out_last_q;

endmodule

// ===== hdl/inode_and_block_bitmap_allocator_core.sv =====
// Top level of the inode and block bitmap allocator.
// Depends on ibba_pkg, ibba_ctrl and ibba_datapath.
//
// Takes one command item at a time (format, allocate, lookup) and returns
// one or more result items, the final one flagged by last_o. Format goes
// from the accepting state straight to its result. Lookup accepts the
// command, reads the inode row and then gives one result per read of the
// block list memory. Allocate passes the accepting state, a check state,
// one claim step per block through the lowest-free-block picker over the
// 64-bit block bitmap plus a step that sees the claim finish, a commit
// state, then one result per read of the list memory. A new command is
// taken once the last result of the previous one sits in the output
// register. No clearing pass is needed after reset.
module inode_and_block_bitmap_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ibba_pkg::CMD_W-1:0]    cmd_i,
  input  logic [ibba_pkg::LEN_W-1:0]    file_length_i,
  input  logic [ibba_pkg::INO_W-1:0]    inode_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ibba_pkg::INO_W-1:0]    inode_number_o,
  output logic [ibba_pkg::BLK_W-1:0]    block_number_o,
  output logic [ibba_pkg::LEN_W-1:0]    stored_length_o,
  output logic [ibba_pkg::CNT_W-1:0]    stored_blocks_o,
  output logic                          last_o
);

  ibba_pkg::ctrl_cmd_t ctrl;
  ibba_pkg::dp_stat_t  stat;

  // Sequencer
  ibba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Bitmaps, inode table and output register
  ibba_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .file_length_i   (file_length_i),
    .inode_index_i   (inode_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .inode_number_o  (inode_number_o),
    .block_number_o  (block_number_o),
    .stored_length_o (stored_length_o),
    .stored_blocks_o (stored_blocks_o),
    .last_o          (last_o)
  );

endmodule

// ===== hdl/ibba_checker.sv =====
// Port-level checks for the bitmap allocator, bound to the top level.
// Depends on ibba_pkg.
module ibba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [ibba_pkg::CMD_W-1:0]    cmd_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [ibba_pkg::INO_W-1:0]    inode_number_o,
  input logic [ibba_pkg::BLK_W-1:0]    block_number_o,
  input logic [ibba_pkg::LEN_W-1:0]    stored_length_o,
  input logic [ibba_pkg::CNT_W-1:0]    stored_blocks_o,
  input logic                          last_o
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(block_number_o) && $stable(last_o))
    else $error("result item changed while stalled");

  // An error result is a single, otherwise empty item
  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ibba_pkg::ST_OK) |-> last_o
      && (inode_number_o == '0) && (block_number_o == '0)
      && (stored_length_o == '0) && (stored_blocks_o == '0))
    else $error("error result carries data");

  // Block count is bounded; an empty file gives one item with block zero
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stored_blocks_o <= ibba_pkg::CNT_W'(ibba_pkg::BLOCKS_PER_FILE))
      && ((stored_blocks_o != '0) || (last_o && (block_number_o == '0))))
    else $error("bad block count in result");

  // Listed blocks always lie in the data area
  a_data_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stored_blocks_o != '0) |->
      (block_number_o >= ibba_pkg::BLK_W'(ibba_pkg::FIRST_DATA_BLOCK)))
    else $error("listed block below the data area");

  // An allocate keeps the input closed for at least the next cycle
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == ibba_pkg::CMD_ALLOC) |=> !in_ready_o)
    else $error("input reopened during allocate");

endmodule

bind inode_and_block_bitmap_allocator_core ibba_checker u_ibba_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for inode_and_block_bitmap_allocator_core: commands are queued, driven
// over valid/ready and scored against a bench-side model of the inode and block bitmaps.
// Depends on ibba_pkg for geometry, field widths, command and status codes.
module tb_top;
  import ibba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DIRECTED     = 25;
  localparam int RANDOM_ITEMS = 245;

  typedef enum logic [1:0] {STIM_CMD, STIM_PACE, STIM_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e       kind;
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] len;
    logic [INO_W-1:0] ino;
    int               gap_pct;
    int               stall_pct;
  } stim_t;

  typedef struct packed {
    status_e          status;
    logic [INO_W-1:0] ino;
    logic [BLK_W-1:0] blk;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } file_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] cmd = CMD_FORMAT;
  logic [LEN_W-1:0] file_length = '0;
  logic [INO_W-1:0] inode_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic [INO_W-1:0] inode_number;
  logic [BLK_W-1:0] block_number;
  logic [LEN_W-1:0] stored_length;
  logic [CNT_W-1:0] stored_blocks;
  logic             last;

  inode_and_block_bitmap_allocator_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .file_length_i   (file_length),
    .inode_index_i   (inode_index),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .inode_number_o  (inode_number),
    .block_number_o  (block_number),
    .stored_length_o (stored_length),
    .stored_blocks_o (stored_blocks),
    .last_o          (last)
  );

  always #5 clk_i = ~clk_i;

  // Model of the file store
  logic [INODE_COUNT-1:0] ino_used;
  logic [BLOCK_TOTAL-1:0] blk_used;
  logic [CNT_W-1:0]       ino_nblk   [INODE_COUNT];
  logic [LEN_W-1:0]       ino_len    [INODE_COUNT];
  logic [BLK_W-1:0]       ino_blocks [INODE_COUNT*BLOCKS_PER_FILE];

  stim_t     cmd_q[$];
  file_row_t due_rows[$];
  int        cmd_count = 0;
  int        errors = 0;
  int        cycles = 0;
  int        gap_pct = 25;
  int        stall_pct = 64;
  int        calm_left = 0;
  logic      in_taken = 1'b0;

  task automatic wipe_store();
    ino_used = '0;
    blk_used = '0;
    for (int i = 0; i < RESERVED_BLOCKS; i++) blk_used[i] = 1'b1;
    foreach (ino_nblk[i]) ino_nblk[i] = '0;
    foreach (ino_len[i]) ino_len[i] = '0;
    foreach (ino_blocks[i]) ino_blocks[i] = '0;
  endtask

  task automatic push_row(input status_e st, input int ino, input int blk, input int len,
                          input int cnt, input logic lst);
    file_row_t r;
    r.status = st;
    r.ino    = INO_W'(ino);
    r.blk    = BLK_W'(blk);
    r.len    = LEN_W'(len);
    r.cnt    = CNT_W'(cnt);
    r.last   = lst;
    due_rows.push_back(r);
  endtask

  // One row per listed block, or a single empty row for a file with no blocks
  task automatic report_file(input int ino);
    int n;
    n = ino_nblk[ino];
    if (n == 0) push_row(ST_OK, ino, 0, ino_len[ino], 0, 1'b1);
    for (int i = 0; i < n; i++)
      push_row(ST_OK, ino, ino_blocks[ino*BLOCKS_PER_FILE + i], ino_len[ino], n, i == n - 1);
  endtask

  task automatic model_allocate(input logic [LEN_W-1:0] len);
    int                     ino;
    int                     need;
    int                     found;
    logic [BLOCK_TOTAL-1:0] trial;
    logic [BLK_W-1:0]       picks [BLOCKS_PER_FILE];
    ino = -1;
    for (int i = INODE_COUNT - 1; i >= 0; i--) if (!ino_used[i]) ino = i;
    if (ino < 0) begin
      push_row(ST_NO_INODE, 0, 0, 0, 0, 1'b1);
      return;
    end
    need = (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (need > BLOCKS_PER_FILE) begin
      push_row(ST_TOO_BIG, 0, 0, 0, 0, 1'b1);
      return;
    end
    // claim on a scratch copy so a shortfall leaves the bitmap untouched
    trial = blk_used;
    found = 0;
    for (int b = FIRST_DATA_BLOCK; b < BLOCK_TOTAL && found < need; b++) begin
      if (!trial[b]) begin
        trial[b] = 1'b1;
        picks[found] = BLK_W'(b);
        found++;
      end
    end
    if (found < need) begin
      push_row(ST_NO_SPACE, 0, 0, 0, 0, 1'b1);
      return;
    end
    blk_used      = trial;
    ino_used[ino] = 1'b1;
    ino_nblk[ino] = CNT_W'(need);
    ino_len[ino]  = len;
    for (int i = 0; i < need; i++) ino_blocks[ino*BLOCKS_PER_FILE + i] = picks[i];
    report_file(ino);
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] len,
                               input logic [INO_W-1:0] ino);
    case (c)
      CMD_FORMAT: begin
        wipe_store();
        push_row(ST_OK, 0, 0, 0, 0, 1'b1);
      end
      CMD_ALLOC:  model_allocate(len);
      CMD_LOOKUP: report_file(int'(ino));
      default: ;
    endcase
  endtask

  // Stimulus queue helpers
  task automatic queue_cmd(input logic [CMD_W-1:0] c, input int len, input int ino);
    stim_t s;
    s.kind = STIM_CMD;
    s.cmd  = c;
    s.len  = LEN_W'(len);
    s.ino  = INO_W'(ino);
    s.gap_pct = 0;
    s.stall_pct = 0;
    cmd_q.push_back(s);
    if (c != CMD_UNUSED) cmd_count++;
  endtask

  task automatic queue_marker(input stim_kind_e k, input int gap, input int stall);
    stim_t s;
    s.kind = k;
    s.cmd  = CMD_FORMAT;
    s.len  = '0;
    s.ino  = '0;
    s.gap_pct = gap;
    s.stall_pct = stall;
    cmd_q.push_back(s);
  endtask

  function automatic int rand_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    if (pick < 40) return $urandom_range(1, BLOCK_BYTES);
    if (pick < 60) return BLOCK_BYTES * $urandom_range(1, BLOCKS_PER_FILE);
    if (pick < 90) return $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES * BLOCKS_PER_FILE);
    return $urandom_range(BLOCK_BYTES * BLOCKS_PER_FILE + 1, 65535);
  endfunction

  function automatic int rand_inode();
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, 7);
    return $urandom_range(0, INODE_COUNT - 1);
  endfunction

  task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Driver: presents commands and the result ready at the falling edge
  always @(negedge clk_i) begin : driver
    stim_t nxt;
    logic  v;
    if (rst_ni) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
      out_ready <= (calm_left > 0) || ($urandom_range(0, 99) >= stall_pct);
      if (!in_valid || in_taken) begin
        v = 1'b0;
        if (cmd_q.size() != 0) begin
          nxt = cmd_q[0];
          case (nxt.kind)
            STIM_PACE: begin
              gap_pct   = nxt.gap_pct;
              stall_pct = nxt.stall_pct;
              void'(cmd_q.pop_front());
            end
            STIM_DRAIN: if (due_rows.size() == 0) void'(cmd_q.pop_front());
            default: begin
              if (calm_left > 0 || $urandom_range(0, 99) >= gap_pct) begin
                v = 1'b1;
                cmd         <= nxt.cmd;
                file_length <= nxt.len;
                inode_index <= nxt.ino;
                void'(cmd_q.pop_front());
              end
            end
          endcase
        end
        in_valid <= v;
      end
    end
  end

  // Monitor: scores results and predicts for each accepted command
  always @(posedge clk_i) begin : monitor
    file_row_t want;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (due_rows.size() == 0) begin
          $display("%0t: unexpected result status %0d inode %0d block %0d", $realtime,
                   status, inode_number, block_number);
          errors++;
        end else begin
          want = due_rows.pop_front();
          check_field("status", want.status, status);
          check_field("inode_number", want.ino, inode_number);
          check_field("block_number", want.blk, block_number);
          check_field("stored_length", want.len, stored_length);
          check_field("stored_blocks", want.cnt, stored_blocks);
          check_field("last", want.last, last);
        end
      end
      if (in_taken) apply_command(cmd, file_length, inode_index);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int n;
    int phase;
    wipe_store();
    queue_marker(STIM_PACE, 25, 64);

    // Directed: empty store, size edges, too-big lengths, ignored code
    queue_cmd(CMD_LOOKUP, 0, 0);
    queue_cmd(CMD_ALLOC, 0, 0);
    queue_cmd(CMD_ALLOC, 1, 0);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES, 0);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES + 1, 0);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES * BLOCKS_PER_FILE, 0);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES * BLOCKS_PER_FILE + 1, 0);
    queue_cmd(CMD_ALLOC, 65535, 31);
    queue_cmd(CMD_LOOKUP, 65535, 0);
    queue_cmd(CMD_LOOKUP, 0, 1);
    queue_cmd(CMD_LOOKUP, 0, 3);
    queue_cmd(CMD_LOOKUP, 0, 4);
    queue_cmd(CMD_LOOKUP, 0, 31);
    queue_cmd(CMD_UNUSED, 65535, 31);
    // exhaust the data blocks, the failing claim must roll back
    for (int i = 0; i < 6; i++) queue_cmd(CMD_ALLOC, BLOCK_BYTES * BLOCKS_PER_FILE, 0);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES * 7, 0);
    queue_cmd(CMD_ALLOC, 1, 0);
    queue_cmd(CMD_FORMAT, 0, 0);
    queue_cmd(CMD_LOOKUP, 0, 4);
    queue_cmd(CMD_ALLOC, BLOCK_BYTES, 0);
    queue_marker(STIM_DRAIN, 0, 0);

    // Random: bursts of mixed commands plus inode and space exhaustion runs
    phase = 0;
    while (cmd_count < DIRECTED + RANDOM_ITEMS) begin
      if (phase == 0 && cmd_count >= DIRECTED + RANDOM_ITEMS / 3) begin
        queue_marker(STIM_DRAIN, 0, 0);
        queue_marker(STIM_PACE, 64, 25);
        phase = 1;
      end else if (phase == 1 && cmd_count >= DIRECTED + 2 * RANDOM_ITEMS / 3) begin
        queue_marker(STIM_DRAIN, 0, 0);
        queue_marker(STIM_PACE, 0, 0);
        phase = 2;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(8, 20);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) queue_cmd(CMD_FORMAT, $urandom_range(0, 65535), rand_inode());
          else if (pick < 52) queue_cmd(CMD_ALLOC, rand_length(), rand_inode());
          else if (pick < 96) queue_cmd(CMD_LOOKUP, $urandom_range(0, 65535), rand_inode());
          else queue_cmd(CMD_UNUSED, $urandom_range(0, 65535), rand_inode());
        end
      end else if (pick < 80) begin
        // run out of inodes, then check that the inode error wins over size
        queue_cmd(CMD_FORMAT, 0, 0);
        for (int i = 0; i <= INODE_COUNT; i++)
          queue_cmd(CMD_ALLOC, $urandom_range(0, BLOCK_BYTES), 0);
        queue_cmd(CMD_ALLOC, 65535, 0);
        for (int i = 0; i < 3; i++) queue_cmd(CMD_LOOKUP, 0, rand_inode());
      end else begin
        // large files that may run out of blocks
        queue_cmd(CMD_FORMAT, 0, 0);
        for (int i = 0; i < 9; i++)
          queue_cmd(CMD_ALLOC, $urandom_range(4 * BLOCK_BYTES + 1,
                                              BLOCK_BYTES * BLOCKS_PER_FILE), 0);
        for (int i = 0; i < 3; i++) queue_cmd(CMD_LOOKUP, 0, $urandom_range(0, 8));
      end
    end

    // Reset, then wait for everything to be sent and answered
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (cmd_q.size() != 0 || in_valid || due_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
